### rtl/socd_pkg.sv
// Shared types and constants for the SOCD direction cleaner.
package socd_pkg;

    typedef enum logic [1:0] {
        MODE_NEUTRAL = 2'd0,
        MODE_LAST    = 2'd1,
        MODE_UP      = 2'd2,
        MODE_FIRST   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef struct packed {
        logic [1:0] direction;
        logic       pressed;
    } t_in;

    typedef struct packed {
        logic out_left;
        logic out_right;
        logic out_up;
        logic out_down;
    } t_out;

endpackage

### rtl/socd_direction_cleaner.sv
// Top level of the SOCD direction cleaner.
//
// Input channel: i_valid / o_ready carry one key event (direction, pressed).
// Output channel: o_valid / i_ready carry the cleaned four-direction result.
// Each accepted event yields exactly one result transfer.
// The result of an event accepted at one edge is
// presented on o_out from that edge onward.
// Throughput is one event per cycle unless the receiver stalls; the held-key update and the output
// logic sit between the state registers and the result register.
// When the receiver stalls, the result register holds its value and o_ready
// drops until the pending result is taken or taken in the same cycle.
// The priority mode is written through i_cfg_we / i_cfg_data and applies to
// the next event; write it only while no result is pending.
// Reset clears the held keys, the axis winners, the mode (neutral) and the
// pending result.
module socd_direction_cleaner
    import socd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_in,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    t_mode r_mode;
    logic  accept;
    logic  space;
    t_out  result;

    assign o_ready = space;
    assign accept  = i_valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NEUTRAL;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    socd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_event  (i_in),
        .i_mode   (r_mode),
        .o_result (result)
    );

    socd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (result),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (o_out),
        .o_space (space)
    );

endmodule

### rtl/socd_core.sv
// Held-key and axis-winner state with the cleaned-output logic.
module socd_core
    import socd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_event,
    input  t_mode i_mode,
    output t_out  o_result
);

    logic [3:0] r_held;
    logic [1:0] r_winner;
    logic [3:0] n_held;
    logic [1:0] n_winner;

    logic       axis;
    logic       side;
    logic       other_held;
    logic [1:0] other_dir;
    logic [1:0] h_out;
    logic [1:0] v_out;

    // Returns {high key, low key} for one axis.
    function automatic logic [1:0] axis_out(input logic lo, input logic hi,
                                            input logic w, input logic vert,
                                            input t_mode mode);
        logic [1:0] res;
        res = {hi, lo};
        if (lo && hi) begin
            unique case (mode)
                MODE_LAST, MODE_FIRST: res = w ? 2'b10 : 2'b01;
                MODE_UP:               res = vert ? 2'b01 : 2'b00;
                default:               res = 2'b00;
            endcase
        end
        return res;
    endfunction

    always_comb begin
        axis       = i_event.direction[1];
        side       = i_event.direction[0];
        other_dir  = {i_event.direction[1], ~i_event.direction[0]};
        other_held = r_held[other_dir];
        n_held     = r_held;
        n_winner   = r_winner;
        if (i_event.pressed) begin
            n_held[i_event.direction] = 1'b1;
            if (!(i_mode == MODE_FIRST && other_held)) begin
                n_winner[axis] = side;
            end
        end else begin
            n_held[i_event.direction] = 1'b0;
            if (other_held) begin
                n_winner[axis] = ~side;
            end
        end
        h_out = axis_out(n_held[DIR_LEFT], n_held[DIR_RIGHT], n_winner[0], 1'b0, i_mode);
        v_out = axis_out(n_held[DIR_UP], n_held[DIR_DOWN], n_winner[1], 1'b1, i_mode);
        o_result.out_left  = h_out[0];
        o_result.out_right = h_out[1];
        o_result.out_up    = v_out[0];
        o_result.out_down  = v_out[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_winner <= '0;
        end else if (i_accept) begin
            r_held   <= n_held;
            r_winner <= n_winner;
        end
    end

endmodule

### rtl/socd_out_reg.sv
// Result register with valid/ready handshake toward the receiver.
module socd_out_reg
    import socd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_out i_data,
    input  logic i_ready,
    output logic o_valid,
    output t_out o_data,
    output logic o_space
);

    logic r_valid;
    t_out r_data;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

### dv/socd_checker.sv
// Checker for the SOCD direction cleaner: predicts each cleaned result and compares transfers.
module socd_checker
    import socd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in        i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out       i_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    logic [3:0] key_held;
    logic [1:0] axis_lead;
    t_mode      key_mode;
    t_out       cleaned_q[$];
    int         mismatches = 0;

    function automatic logic [1:0] resolve_axis(input logic [1:0] pair, input logic lead,
                                                input logic vertical, input t_mode mode);
        if (pair != 2'b11) begin
            return pair;
        end
        case (mode)
            MODE_LAST, MODE_FIRST: begin
                return lead ? 2'b10 : 2'b01;
            end
            MODE_UP: begin
                return vertical ? 2'b01 : 2'b00;
            end
            default: begin
                return 2'b00;
            end
        endcase
    endfunction

    task automatic clean_key_event(input t_in ev, output t_out res);
        logic       axis;
        logic       side;
        logic       other_held;
        logic [1:0] h;
        logic [1:0] v;
        axis = ev.direction[1];
        side = ev.direction[0];
        other_held = key_held[ev.direction ^ 2'd1];
        if (ev.pressed) begin
            key_held[ev.direction] = 1'b1;
            if (!(key_mode == MODE_FIRST && other_held)) begin
                axis_lead[axis] = side;
            end
        end else begin
            key_held[ev.direction] = 1'b0;
            if (other_held) begin
                axis_lead[axis] = ~side;
            end
        end
        h = resolve_axis(key_held[1:0], axis_lead[0], 1'b0, key_mode);
        v = resolve_axis(key_held[3:2], axis_lead[1], 1'b1, key_mode);
        res = '{out_left: h[0], out_right: h[1], out_up: v[0], out_down: v[1]};
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            key_held = '0;
            axis_lead = '0;
            key_mode = MODE_NEUTRAL;
            cleaned_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (cleaned_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, i_out_item);
                    mismatches++;
                end else begin
                    want = cleaned_q.pop_front();
                    check_field("out_left", want.out_left, i_out_item.out_left);
                    check_field("out_right", want.out_right, i_out_item.out_right);
                    check_field("out_up", want.out_up, i_out_item.out_up);
                    check_field("out_down", want.out_down, i_out_item.out_down);
                end
            end
            if (i_in_valid && i_in_ready) begin
                clean_key_event(i_in_item, want);
                cleaned_q.push_back(want);
            end
            if (i_cfg_we) begin
                key_mode = t_mode'(i_cfg_data);
            end
        end
        o_fail_count <= mismatches;
        o_pending <= cleaned_q.size();
    end

endmodule

### dv/tb_top.sv
// Testbench top for the SOCD direction cleaner: clock, reset, stimulus and verdict.
module tb_top;
    import socd_pkg::*;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_EVENTS = 250;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in        i_in = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out       o_out;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;

    logic [15:0] ready_pattern = 16'hffff;
    int          pattern_age = 0;
    int          burst_left = 0;

    always #5 i_clk = ~i_clk;

    socd_direction_cleaner uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    socd_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_in),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (pattern_age == 63) begin
            case ($urandom_range(0, 3))
                0: begin
                    ready_pattern <= 16'hffff;
                end
                default: begin
                    ready_pattern <= 16'($urandom);
                end
            endcase
            pattern_age <= 0;
        end else begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            pattern_age <= pattern_age + 1;
        end
        i_ready <= ready_pattern[15];
    end

    function automatic t_in key_event(input t_dir d, input logic p);
        t_in ev;
        ev.direction = d;
        ev.pressed = p;
        return ev;
    endfunction

    function automatic t_in random_key_event();
        t_in ev;
        ev.direction = 2'($urandom_range(0, 3));
        ev.pressed = ($urandom_range(0, 99) < 55);
        return ev;
    endfunction

    task automatic send_event(input t_in ev);
        i_valid <= 1'b1;
        i_in <= ev;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic paced_send(input t_in ev);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_event(ev);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(MODE_LAST);
        send_event(key_event(DIR_LEFT, 1'b1));
        send_event(key_event(DIR_RIGHT, 1'b1));
        send_event(key_event(DIR_RIGHT, 1'b0));
        send_event(key_event(DIR_UP, 1'b1));
        send_event(key_event(DIR_DOWN, 1'b1));
        send_event(key_event(DIR_UP, 1'b0));
        send_event(key_event(DIR_LEFT, 1'b0));
        send_event(key_event(DIR_DOWN, 1'b0));
        send_event(key_event(DIR_LEFT, 1'b0));

        set_mode(MODE_FIRST);
        send_event(key_event(DIR_RIGHT, 1'b1));
        send_event(key_event(DIR_LEFT, 1'b1));
        send_event(key_event(DIR_RIGHT, 1'b1));
        send_event(key_event(DIR_DOWN, 1'b1));
        send_event(key_event(DIR_UP, 1'b1));

        // The held keys carry over, so the new mode applies to both axes at once.
        set_mode(MODE_UP);
        send_event(key_event(DIR_UP, 1'b0));
        send_event(key_event(DIR_UP, 1'b1));

        set_mode(MODE_NEUTRAL);
        send_event(key_event(DIR_DOWN, 1'b1));
        send_event(key_event(DIR_RIGHT, 1'b0));
        send_event(key_event(DIR_LEFT, 1'b0));
        send_event(key_event(DIR_DOWN, 1'b0));
        send_event(key_event(DIR_UP, 1'b0));

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_mode(phase < 4 ? t_mode'(phase) : t_mode'($urandom_range(0, 3)));
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
                paced_send(random_key_event());
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("socd_direction_cleaner regression: pass");
        end else begin
            $display("socd_direction_cleaner regression: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("socd_direction_cleaner regression: fail");
        $finish;
    end

endmodule
